[rtl/core/es2c_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// es2c_pkg: shared types and constants for the epoch seconds converter
// command and status structs between controller and datapath, reciprocal
// constants for the division steps and the result field layout
// ----------------------------------------------------------------------------
package es2c_pkg;

    // datapath commands, one per controller step
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_SEC    = 4'd2,
        OP_MIN    = 4'd3,
        OP_HOUR   = 4'd4,
        OP_WDAY   = 4'd5,
        OP_YSPLIT = 4'd6,
        OP_YEAR   = 4'd7,
        OP_MONTH  = 4'd8,
        OP_OUT    = 4'd9
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic rejected;
        logic year_fit;
        logic month_done;
    } stat_t;

    // widths of the streams
    localparam int IN_W  = 32;
    localparam int OUT_W = 48;

    // result field layout in m_axis_tdata, lowest bit of each field
    localparam int SEC_LSB   = 0;
    localparam int MIN_LSB   = 6;
    localparam int HOUR_LSB  = 12;
    localparam int DAY_LSB   = 17;
    localparam int MONTH_LSB = 22;
    localparam int YEAR_LSB  = 26;
    localparam int WDAY_LSB  = 34;
    localparam int YDAY_LSB  = 37;

    // reciprocal constants: q = (x * M) >> S, exact over the value ranges met
    localparam logic [31:0] M_DIV60   = 32'd2290649225;
    localparam int          S_DIV60   = 37;
    localparam logic [31:0] M_DIV24   = 32'd2863311531;
    localparam int          S_DIV24   = 36;
    localparam logic [31:0] M_DIV7    = 32'd149797;
    localparam int          S_DIV7    = 20;
    localparam logic [31:0] M_DIV1461 = 32'd734937;
    localparam int          S_DIV1461 = 30;

    localparam logic [10:0] DAYS_4YEARS   = 11'd1461;
    localparam logic [10:0] DAYS_YEAR     = 11'd365;
    localparam logic [10:0] DAYS_LEAPYEAR = 11'd366;
    localparam logic [7:0]  BASE_YEAR     = 8'd70;
    localparam logic [14:0] EPOCH_WDAY    = 15'd4;
    localparam logic [8:0]  LEAP_DAY      = 9'd60;
    localparam logic [8:0]  FEB_29        = 9'd29;
    localparam logic [3:0]  MONTH_FEB     = 4'd1;
    localparam logic [3:0]  MONTH_DEC     = 4'd11;

    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[rtl/core/epoch_seconds_to_calendar.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: unix seconds to utc broken-down time
// a sequencer drives a datapath built round one shared reciprocal multiplier
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item: a 32-bit count of seconds since 1970-01-01 utc.
//   m_axis returns one result item per input item, in order: second, minute,
//   hour, day of month, month, years since 1900, weekday and day of year in
//   tdata, and a rejected flag in tuser for inputs above 0x7fffffff, in
//   which case every tdata field is zero.
//   one item is converted at a time. after acceptance the datapath runs five
//   division steps, one to four year steps and one to twelve month steps,
//   then loads the result register; a rejected item goes from the first
//   division step straight to the result register load. the year and month
//   walks make the conversion time vary from item to item.
//   the result register parts the two sides: a new item is taken while the
//   previous result waits, and a finished conversion holds in its last step
//   until the result register is free, so a stalled receiver loses nothing.
//   reset (rst_n low, asynchronous) empties the block: s_axis_tready comes up
//   high and m_axis_tvalid low.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
    // [25:22] month, [33:26] year_since_1900, [36:34] weekday,
    // [45:37] day_of_year, [47:46] zero
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser    // [0] rejected
);

    es2c_pkg::cmd_t  cmd;
    es2c_pkg::stat_t stat;

    es2c_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    es2c_dp u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .in_data      (s_axis_tdata),
        .stat         (stat),
        .out_data     (m_axis_tdata),
        .out_rejected (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // a rejected result carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected result with non-zero fields");

    // one item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while converting");

    // an accepted result has a real date
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
        m_axis_tdata[es2c_pkg::MONTH_LSB +: 4] < 4'd12 &&
        m_axis_tdata[es2c_pkg::DAY_LSB +: 5] != 5'd0)
        else $error("month or day of month out of range");

    // clock fields in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
        m_axis_tdata[es2c_pkg::HOUR_LSB +: 5] < 5'd24 &&
        m_axis_tdata[es2c_pkg::MIN_LSB +: 6] < 6'd60 &&
        m_axis_tdata[es2c_pkg::SEC_LSB +: 6] < 6'd60)
        else $error("time of day out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/es2c_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// es2c_dp: converter datapath
// one shared reciprocal multiplier for the divisions by 60, 60, 24, 7 and
// 1461, a year stepper, a month stepper and the result register
// ----------------------------------------------------------------------------
module es2c_dp (
    input  wire logic                         clk,
    input  wire es2c_pkg::cmd_t               cmd,
    input  wire logic [es2c_pkg::IN_W-1:0]    in_data,
    output es2c_pkg::stat_t                   stat,
    output logic      [es2c_pkg::OUT_W-1:0]   out_data,
    output logic                              out_rejected
);

    logic [30:0] x_reg;
    logic [62:0] prod_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hr_reg;
    logic [2:0]  wday_reg;
    logic [7:0]  year_reg;
    logic [8:0]  yday_reg;
    logic [8:0]  day_reg;
    logic [3:0]  mon_reg;
    logic        rej_reg;
    logic        hold_reg;
    logic [es2c_pkg::OUT_W-1:0] out_data_reg;
    logic        out_rej_reg;

    logic [30:0] mul_a;
    logic [31:0] mul_b;
    logic [62:0] mul_prod;

    logic [25:0] q_sec;
    logic [19:0] q_min;
    logic [14:0] q_hr;
    logic [11:0] q_wd;
    logic [4:0]  q_4y;

    logic        leap;
    logic [10:0] span;
    logic        fit;
    logic [8:0]  day_one;
    logic [4:0]  mlen;
    logic        walk;

    // quotients of the previous multiply
    assign q_sec = prod_reg[es2c_pkg::S_DIV60 +: 26];
    assign q_min = prod_reg[es2c_pkg::S_DIV60 +: 20];
    assign q_hr  = prod_reg[es2c_pkg::S_DIV24 +: 15];
    assign q_wd  = prod_reg[es2c_pkg::S_DIV7 +: 12];
    assign q_4y  = prod_reg[es2c_pkg::S_DIV1461 +: 5];

    always_comb
    begin
        case (cmd.op)
            es2c_pkg::OP_LOAD:
            begin
                mul_a = in_data[30:0];
                mul_b = es2c_pkg::M_DIV60;
            end
            es2c_pkg::OP_SEC:
            begin
                mul_a = 31'(q_sec);
                mul_b = es2c_pkg::M_DIV60;
            end
            es2c_pkg::OP_MIN:
            begin
                mul_a = 31'(q_min);
                mul_b = es2c_pkg::M_DIV24;
            end
            es2c_pkg::OP_HOUR:
            begin
                // day count plus the epoch weekday (thursday)
                mul_a = 31'(q_hr + es2c_pkg::EPOCH_WDAY);
                mul_b = es2c_pkg::M_DIV7;
            end
            es2c_pkg::OP_WDAY:
            begin
                mul_a = x_reg;
                mul_b = es2c_pkg::M_DIV1461;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = 63'(mul_a) * 63'(mul_b);

    assign leap    = (year_reg[1:0] == 2'b00);
    assign span    = leap ? es2c_pkg::DAYS_LEAPYEAR : es2c_pkg::DAYS_YEAR;
    assign fit     = (x_reg[10:0] < span);
    assign day_one = x_reg[8:0] + 9'd1;
    assign mlen    = es2c_pkg::month_len(mon_reg);
    assign walk    = !hold_reg && (mon_reg < es2c_pkg::MONTH_DEC) && (9'(mlen) < day_reg);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            es2c_pkg::OP_LOAD:
            begin
                x_reg    <= in_data[30:0];
                rej_reg  <= in_data[31];
                prod_reg <= mul_prod;
            end
            es2c_pkg::OP_SEC:
            begin
                sec_reg  <= 6'(x_reg - 31'(q_sec) * 31'd60);
                x_reg    <= 31'(q_sec);
                prod_reg <= mul_prod;
            end
            es2c_pkg::OP_MIN:
            begin
                min_reg  <= 6'(x_reg[25:0] - 26'(q_min) * 26'd60);
                x_reg    <= 31'(q_min);
                prod_reg <= mul_prod;
            end
            es2c_pkg::OP_HOUR:
            begin
                hr_reg   <= 5'(x_reg[19:0] - 20'(q_hr) * 20'd24);
                x_reg    <= 31'(q_hr);
                prod_reg <= mul_prod;
            end
            es2c_pkg::OP_WDAY:
            begin
                wday_reg <= 3'((x_reg[14:0] + es2c_pkg::EPOCH_WDAY) - 15'(q_wd) * 15'd7);
                prod_reg <= mul_prod;
            end
            es2c_pkg::OP_YSPLIT:
            begin
                x_reg    <= 31'(x_reg[14:0] - 15'(q_4y) * 15'(es2c_pkg::DAYS_4YEARS));
                year_reg <= es2c_pkg::BASE_YEAR + 8'({q_4y, 2'b00});
            end
            es2c_pkg::OP_YEAR:
            begin
                if (!fit)
                begin
                    x_reg    <= 31'(x_reg[10:0] - span);
                    year_reg <= year_reg + 8'd1;
                end
                else
                begin
                    yday_reg <= x_reg[8:0];
                    // leap day is reported directly, later days drop by one
                    if (leap && day_one == es2c_pkg::LEAP_DAY)
                    begin
                        day_reg  <= es2c_pkg::FEB_29;
                        mon_reg  <= es2c_pkg::MONTH_FEB;
                        hold_reg <= 1'b1;
                    end
                    else
                    begin
                        day_reg  <= (leap && day_one > es2c_pkg::LEAP_DAY) ?
                                    day_one - 9'd1 : day_one;
                        mon_reg  <= '0;
                        hold_reg <= 1'b0;
                    end
                end
            end
            es2c_pkg::OP_MONTH:
            begin
                day_reg <= day_reg - 9'(mlen);
                mon_reg <= mon_reg + 4'd1;
            end
            es2c_pkg::OP_OUT:
            begin
                out_rej_reg <= rej_reg;
                if (rej_reg)
                begin
                    out_data_reg <= '0;
                end
                else
                begin
                    out_data_reg <= {2'b00, yday_reg, wday_reg, year_reg, mon_reg,
                                     day_reg[4:0], hr_reg, min_reg, sec_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.rejected   = rej_reg;
    assign stat.year_fit   = fit;
    assign stat.month_done = !walk;
    assign out_data        = out_data_reg;
    assign out_rejected    = out_rej_reg;

endmodule
`default_nettype wire

[rtl/core/es2c_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// es2c_ctrl: converter sequencer
// steps the datapath through the divisions, the year walk and the month walk,
// and owns the input ready and the result valid
// ----------------------------------------------------------------------------
module es2c_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire es2c_pkg::stat_t stat,
    output es2c_pkg::cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SEC    = 9'b000000010,
        ST_MIN    = 9'b000000100,
        ST_HOUR   = 9'b000001000,
        ST_WDAY   = 9'b000010000,
        ST_YSPLIT = 9'b000100000,
        ST_YEAR   = 9'b001000000,
        ST_MONTH  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = es2c_pkg::OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = es2c_pkg::OP_LOAD;
                    state_next = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (stat.rejected)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = es2c_pkg::OP_SEC;
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                cmd.op     = es2c_pkg::OP_MIN;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                cmd.op     = es2c_pkg::OP_HOUR;
                state_next = ST_WDAY;
            end
            ST_WDAY:
            begin
                cmd.op     = es2c_pkg::OP_WDAY;
                state_next = ST_YSPLIT;
            end
            ST_YSPLIT:
            begin
                cmd.op     = es2c_pkg::OP_YSPLIT;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                cmd.op = es2c_pkg::OP_YEAR;
                if (stat.year_fit)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (stat.month_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op = es2c_pkg::OP_MONTH;
                end
            end
            ST_DONE:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = es2c_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[test/tb_epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar: self-checking bench for the seconds converter
// a short table of hand-picked timestamps (epoch start, the 2038 limit, leap
// days, year and month edges, rejected inputs), then random timestamps
// weighted towards calendar edges; every result is compared field by field
// with an in-bench calendar model or a typed-in date while both stream sides idle at random
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          RANDOM_ITEMS    = 1950;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int unsigned LAST_ACCEPTED   = 32'h7FFF_FFFF;
    localparam int unsigned SECS_PER_DAY    = 86400;
    localparam int unsigned HOURS_IN_YEAR   = 8760;
    localparam int unsigned HOURS_IN_CYCLE  = 35064;
    localparam int unsigned FIRST_YEAR      = 70;
    localparam int unsigned LAST_YEAR       = 138;
    localparam int unsigned THURSDAY        = 4;
    localparam int unsigned LEAP_DAY_NUMBER = 60;
    localparam int unsigned LAST_DAY_2038   = 17;

    localparam int unsigned DAYS_IN_MONTH [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] year_since_1900;
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic       rejected;
    } calendar_t;

    typedef struct {
        logic [31:0] epoch;
        bit          typed_in;
        calendar_t   known;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    calendar_t   pending_dates [$];
    stim_row_t   directed [$];
    int          failures = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    epoch_seconds_to_calendar i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit is_leap_year(input int unsigned yr);
        return (yr % 4) == 0;
    endfunction

    function automatic calendar_t to_calendar(input logic [31:0] epoch);
        calendar_t   r;
        int unsigned t;
        int unsigned hours;
        int unsigned yr;
        int unsigned day;
        int unsigned mon;
        r = '0;
        if (epoch > LAST_ACCEPTED)
        begin
            r.rejected = 1'b1;
            return r;
        end
        t        = epoch;
        r.second = 6'(t % 60);
        t        = t / 60;
        r.minute = 6'(t % 60);
        hours    = t / 60;
        r.weekday = 3'((hours / 24 + THURSDAY) % 7);
        // whole four-year blocks first, each starting two years after a leap year
        yr = (hours / HOURS_IN_CYCLE) * 4 + FIRST_YEAR;
        t  = hours % HOURS_IN_CYCLE;
        while (t >= HOURS_IN_YEAR + (is_leap_year(yr) ? 24 : 0))
        begin
            t  = t - (HOURS_IN_YEAR + (is_leap_year(yr) ? 24 : 0));
            yr = yr + 1;
        end
        r.hour        = 5'(t % 24);
        day           = t / 24 + 1;
        r.day_of_year = 9'(day - 1);
        mon           = 0;
        if (is_leap_year(yr) && day == LEAP_DAY_NUMBER)
        begin
            mon = 1;
            day = 29;
        end
        else
        begin
            if (is_leap_year(yr) && day > LEAP_DAY_NUMBER)
                day = day - 1;
            while (mon < 11 && DAYS_IN_MONTH[mon] < day)
            begin
                day = day - DAYS_IN_MONTH[mon];
                mon = mon + 1;
            end
        end
        r.day_of_month    = 5'(day);
        r.month           = 4'(mon);
        r.year_since_1900 = 8'(yr);
        return r;
    endfunction

    function automatic stim_row_t row(input logic [31:0] epoch, input bit typed_in,
                                      input calendar_t known);
        stim_row_t r;
        r.epoch    = epoch;
        r.typed_in = typed_in;
        r.known    = known;
        return r;
    endfunction

    function automatic calendar_t date(input int sec, input int min, input int hr,
                                       input int mday, input int mon, input int yr,
                                       input int wday, input int yday);
        calendar_t c;
        c.second          = 6'(sec);
        c.minute          = 6'(min);
        c.hour            = 5'(hr);
        c.day_of_month    = 5'(mday);
        c.month           = 4'(mon);
        c.year_since_1900 = 8'(yr);
        c.weekday         = 3'(wday);
        c.day_of_year     = 9'(yday);
        c.rejected        = 1'b0;
        return c;
    endfunction

    // random timestamp, partly near year, month and leap-day edges
    function automatic logic [31:0] random_epoch();
        int unsigned pick;
        int unsigned yr;
        int unsigned first_day;
        int unsigned day;
        int unsigned year_len;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom_range(0, LAST_ACCEPTED);
        if (pick < 62)
            return $urandom | 32'h8000_0000;
        if (pick < 70)
            return $urandom;
        yr        = $urandom_range(FIRST_YEAR, LAST_YEAR);
        first_day = (yr - FIRST_YEAR) * 365 + (yr - FIRST_YEAR + 1) / 4;
        year_len  = is_leap_year(yr) ? 366 : 365;
        case ($urandom_range(0, 7))
            0:       day = 0;
            1:       day = $urandom_range(28, 32);
            2:       day = $urandom_range(57, 61);
            3:       day = year_len - 1 - $urandom_range(0, 1);
            default: day = $urandom_range(0, year_len - 1);
        endcase
        if (yr == LAST_YEAR)
            day = day % (LAST_DAY_2038 + 1);
        if ($urandom_range(0, 3) == 0)
            return (first_day + day) * SECS_PER_DAY + $urandom_range(86390, 86399);
        return (first_day + day) * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
    endfunction

    task automatic send_item(input logic [31:0] epoch, input bit typed_in,
                             input calendar_t known);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= epoch;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_dates.push_back(typed_in ? known : to_calendar(epoch));
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_result();
        calendar_t want;
        calendar_t got;
        got.second          = m_axis_tdata[es2c_pkg::SEC_LSB +: 6];
        got.minute          = m_axis_tdata[es2c_pkg::MIN_LSB +: 6];
        got.hour            = m_axis_tdata[es2c_pkg::HOUR_LSB +: 5];
        got.day_of_month    = m_axis_tdata[es2c_pkg::DAY_LSB +: 5];
        got.month           = m_axis_tdata[es2c_pkg::MONTH_LSB +: 4];
        got.year_since_1900 = m_axis_tdata[es2c_pkg::YEAR_LSB +: 8];
        got.weekday         = m_axis_tdata[es2c_pkg::WDAY_LSB +: 3];
        got.day_of_year     = m_axis_tdata[es2c_pkg::YDAY_LSB +: 9];
        got.rejected        = m_axis_tuser;
        if (pending_dates.size() == 0)
        begin
            $error("result item with nothing outstanding");
            failures++;
            return;
        end
        want = pending_dates.pop_front();
        compare_field("second", 32'(want.second), 32'(got.second));
        compare_field("minute", 32'(want.minute), 32'(got.minute));
        compare_field("hour", 32'(want.hour), 32'(got.hour));
        compare_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
        compare_field("month", 32'(want.month), 32'(got.month));
        compare_field("year_since_1900", 32'(want.year_since_1900),
                      32'(got.year_since_1900));
        compare_field("weekday", 32'(want.weekday), 32'(got.weekday));
        compare_field("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
        compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
        compare_field("tdata upper bits", 0, 32'(m_axis_tdata[47:46]));
    endtask

    // result side: random stall before each item
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            check_result();
            @(negedge clk);
        end
    end

    initial
    begin
        calendar_t none;
        calendar_t refused;
        none     = '0;
        refused  = '0;
        refused.rejected = 1'b1;

        directed.push_back(row(32'd0, 1'b1, date(0, 0, 0, 1, 0, 70, 4, 0)));
        directed.push_back(row(32'h7FFF_FFFF, 1'b1, date(7, 14, 3, 19, 0, 138, 2, 18)));
        directed.push_back(row(32'h8000_0000, 1'b1, refused));
        directed.push_back(row(32'hFFFF_FFFF, 1'b1, refused));
        directed.push_back(row(32'hAAAA_AAAA, 1'b1, refused));
        directed.push_back(row(32'h5555_5555, 1'b0, none));
        directed.push_back(row(32'd59, 1'b0, none));
        directed.push_back(row(32'd60, 1'b0, none));
        directed.push_back(row(32'd3599, 1'b0, none));
        directed.push_back(row(32'd3600, 1'b0, none));
        directed.push_back(row(32'd86399, 1'b0, none));
        directed.push_back(row(32'd86400, 1'b0, none));
        // year edges, 1972 leap day and its neighbours
        directed.push_back(row(32'd31535999, 1'b0, none));
        directed.push_back(row(32'd31536000, 1'b0, none));
        directed.push_back(row(32'd63071999, 1'b0, none));
        directed.push_back(row(32'd63072000, 1'b0, none));
        directed.push_back(row(32'd68169599, 1'b0, none));
        directed.push_back(row(32'd68169600, 1'b0, none));
        directed.push_back(row(32'd68256000, 1'b0, none));
        directed.push_back(row(32'd94694399, 1'b0, none));
        directed.push_back(row(32'd94694400, 1'b0, none));
        directed.push_back(row(32'd951782400, 1'b0, none));
        directed.push_back(row(32'd978307199, 1'b0, none));
        directed.push_back(row(32'd2145916800, 1'b0, none));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i].epoch, directed[i].typed_in, directed[i].known);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every fourth stretch of items runs with both sides flat out
            no_idle = ((n / 150) % 4) == 3;
            send_item(random_epoch(), 1'b0, none);
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
